>>> rtl/core/dqnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnp_pkg
// shared types and constants of the dns question name parser
// ----------------------------------------------------------------------------
package dqnp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LEN     = 3'd2,
    PH_LABEL   = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  // result kind
  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_ESC       = 3'd1,
    KIND_SEP       = 3'd2,
    KIND_QDONE     = 3'd3,
    KIND_MALFORMED = 3'd4,
    KIND_TRUNC     = 3'd5
  } kind_e;

  // position within the qtype / qclass trailer of a question
  typedef enum logic [1:0] {
    TRL_QTYPE_HI  = 2'd0,
    TRL_QTYPE_LO  = 2'd1,
    TRL_QCLASS_HI = 2'd2,
    TRL_QCLASS_LO = 2'd3
  } trl_e;

  localparam logic [3:0] HdrFlagsIdx = 4'd2;
  localparam logic [3:0] HdrQdHiIdx  = 4'd4;
  localparam logic [3:0] HdrQdLoIdx  = 4'd5;
  localparam logic [3:0] HdrLastIdx  = 4'd11;

  localparam logic [7:0] CharLo = 8'd33;
  localparam logic [7:0] CharHi = 8'd127;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic        eom;
  } res_t;

endpackage

>>> rtl/core/dns_question_name_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_question_name_parser
// byte-wide parser of the question section of a dns message
// ----------------------------------------------------------------------------
// Takes one message byte per beat, msg_first on the first header byte and
// msg_last on the final byte, and gives at most one result beat per input
// beat: characters, escaped bytes and separators of each question name, then
// the qtype of each question, or a malformed or truncated marker. Responses
// and bytes outside a message give nothing. A byte is taken every cycle while
// the output side keeps up; a result passes from the input register through
// the parser core into the result register, which holds it on the output
// until it is taken. Throughput is set by the state update in the parser core.
module dns_question_name_parser import dqnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        msg_first_i,
  input  logic        msg_last_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] value_o,
  output logic        end_of_message_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_first_q, s1_last_q;

  logic in_acc, s1_adv, out_free, res_valid;
  res_t res, out_res;

  // the held beat moves on when it has no result or the result slot is free
  assign s1_adv     = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // beat payload, loaded only on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= msg_first_i;
      s1_last_q  <= msg_last_i;
    end
  end

  // parser state and per-byte decode
  dqnp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .data_byte_i (s1_byte_q),
    .msg_first_i (s1_first_q),
    .msg_last_i  (s1_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register towards the output channel
  dqnp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_adv && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign kind_o           = out_res.kind;
  assign value_o          = out_res.value;
  assign end_of_message_o = out_res.eom;

endmodule

>>> rtl/core/dqnp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnp_core
// parser state and per-byte update, one beat per enable
// ----------------------------------------------------------------------------
module dqnp_core import dqnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] data_byte_i,
  input  logic       msg_first_i,
  input  logic       msg_last_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [3:0]  hidx_q, hidx_d, cur_hidx;
  logic [15:0] qleft_q, qleft_d, cur_qleft, qleft_dec;
  logic [7:0]  lbl_q, lbl_d, cur_lbl, lbl_dec;
  logic        started_q, started_d, cur_started;
  logic [7:0]  qth_q, qth_d, cur_qth;
  trl_e        trl_q, trl_d, cur_trl;
  logic        no_trunc;

  // msg_first restarts the parser before the byte is looked at
  always_comb begin
    cur_phase   = msg_first_i ? PH_HEADER    : phase_q;
    cur_hidx    = msg_first_i ? 4'd0         : hidx_q;
    cur_qleft   = msg_first_i ? 16'd0        : qleft_q;
    cur_lbl     = msg_first_i ? 8'd0         : lbl_q;
    cur_started = msg_first_i ? 1'b0         : started_q;
    cur_qth     = msg_first_i ? 8'd0         : qth_q;
    cur_trl     = msg_first_i ? TRL_QTYPE_HI : trl_q;
  end

  assign qleft_dec = cur_qleft - 16'd1;
  assign lbl_dec   = cur_lbl - 8'd1;

  always_comb begin
    phase_d     = cur_phase;
    hidx_d      = cur_hidx;
    qleft_d     = cur_qleft;
    lbl_d       = cur_lbl;
    started_d   = cur_started;
    qth_d       = cur_qth;
    trl_d       = cur_trl;
    no_trunc    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_SEP, value: 16'd0, eom: 1'b0};

    case (cur_phase)
      PH_HEADER: begin
        if (cur_hidx == HdrFlagsIdx && data_byte_i[7]) begin
          // response: dropped silently
          phase_d  = PH_DONE;
          no_trunc = 1'b1;
        end else begin
          if (cur_hidx == HdrQdHiIdx) begin
            qleft_d = {data_byte_i, 8'd0};
          end else if (cur_hidx == HdrQdLoIdx) begin
            qleft_d = {cur_qleft[15:8], cur_qleft[7:0] | data_byte_i};
          end
          if (cur_hidx >= HdrLastIdx) begin
            if (cur_qleft == 16'd0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d   = PH_LEN;
              started_d = 1'b0;
            end
          end else begin
            hidx_d = cur_hidx + 4'd1;
          end
        end
      end
      PH_LEN: begin
        if (data_byte_i == 8'd0) begin
          if (!cur_started) begin
            res_valid_o = 1'b1;
            res_o       = '{kind: KIND_MALFORMED, value: 16'd0, eom: 1'b1};
            phase_d     = PH_DONE;
            no_trunc    = 1'b1;
          end else begin
            res_valid_o = 1'b1;
            phase_d     = PH_TRAILER;
            trl_d       = TRL_QTYPE_HI;
          end
        end else begin
          res_valid_o = cur_started;
          started_d   = 1'b1;
          lbl_d       = data_byte_i;
          phase_d     = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (data_byte_i == 8'd0) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_MALFORMED, value: 16'd0, eom: 1'b1};
          phase_d     = PH_DONE;
          no_trunc    = 1'b1;
        end else begin
          res_valid_o = 1'b1;
          res_o.value = {8'd0, data_byte_i};
          res_o.kind  = (data_byte_i inside {[CharLo:CharHi]}) ? KIND_CHAR : KIND_ESC;
          lbl_d       = lbl_dec;
          if (lbl_dec == 8'd0) begin
            phase_d = PH_LEN;
          end
        end
      end
      PH_TRAILER: begin
        case (cur_trl)
          TRL_QTYPE_HI: begin
            qth_d = data_byte_i;
            trl_d = TRL_QTYPE_LO;
          end
          TRL_QTYPE_LO: begin
            qleft_d     = qleft_dec;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_QDONE;
            res_o.value = {cur_qth, data_byte_i};
            if (qleft_dec == 16'd0) begin
              // last question: rest of the message is ignored
              res_o.eom = 1'b1;
              phase_d   = PH_DONE;
              no_trunc  = 1'b1;
            end else begin
              trl_d = TRL_QCLASS_HI;
            end
          end
          TRL_QCLASS_HI: begin
            trl_d = TRL_QCLASS_LO;
          end
          default: begin
            trl_d     = TRL_QTYPE_HI;
            started_d = 1'b0;
            phase_d   = PH_LEN;
          end
        endcase
      end
      default: begin
        // idle or done: byte ignored
        no_trunc = 1'b1;
      end
    endcase

    // message ends while still unfinished
    if (msg_last_i && !no_trunc && phase_d != PH_DONE && phase_d != PH_IDLE) begin
      res_valid_o = 1'b1;
      res_o       = '{kind: KIND_TRUNC, value: 16'd0, eom: 1'b1};
      phase_d     = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hidx_q    <= 4'd0;
      qleft_q   <= 16'd0;
      lbl_q     <= 8'd0;
      started_q <= 1'b0;
      qth_q     <= 8'd0;
      trl_q     <= TRL_QTYPE_HI;
    end else if (en_i) begin
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      qleft_q   <= qleft_d;
      lbl_q     <= lbl_d;
      started_q <= started_d;
      qth_q     <= qth_d;
      trl_q     <= trl_d;
    end
  end

  // error results always close the message
  a_err_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_MALFORMED || res_o.kind == KIND_TRUNC) |-> res_o.eom)
    else $error("error result without end of message");

  // no results outside a message
  a_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !msg_first_i && (phase_q == PH_IDLE || phase_q == PH_DONE) |-> !res_valid_o)
    else $error("result outside a message");

  // a committed end of message leaves the parser done
  a_eom_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_valid_o && res_o.eom |=> phase_q == PH_DONE)
    else $error("end of message did not close the parser");

  // label body always has bytes still to come
  a_label_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LABEL |-> lbl_q != 8'd0)
    else $error("empty label body");

endmodule

>>> rtl/core/dqnp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqnp_out_reg
// result register holding one beat for the output channel
// ----------------------------------------------------------------------------
module dqnp_out_reg import dqnp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  res_t  res_i,
  output logic  free_o,
  output logic  valid_o,
  input  logic  stall_i,
  output res_t  res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i ? 1'b1 : (stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> dv/dns_question_name_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_question_name_parser_tb
// self-checking bench for the dns question name parser
// ----------------------------------------------------------------------------
// Feeds whole and broken dns messages byte by byte through the input channel,
// predicts every result beat from its own model of the parser and compares
// each accepted result beat, field by field, with the oldest prediction.
// Both channels idle in random bursts, except near the end of the run.
module dns_question_name_parser_tb;
  import dqnp_pkg::*;

  localparam int IdleLimit  = 1000;  // cycles with no beat on either side
  localparam int CalmTail   = 80;    // last beats are sent with no idling
  localparam int RandItems  = 600;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
  } in_beat_t;

  // ways to spoil a question name
  typedef enum int {
    FLAW_NONE,
    FLAW_EMPTY_LABEL,
    FLAW_ZERO_BYTE
  } flaw_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        msg_first = 1'b0;
  logic        msg_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [15:0] value;
  logic        end_of_message;

  in_beat_t    pend_beats[$];   // beats still to be sent
  res_t        expected_q[$];   // predicted result beats, oldest first
  logic [7:0]  msg_bytes[$];    // message under construction
  int          stim_items = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          in_took = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;

  // parser model state
  phase_e      p_phase = PH_IDLE;
  logic [3:0]  p_hdr_idx = '0;
  logic [15:0] p_q_left = '0;
  logic [7:0]  p_lbl_left = '0;
  logic        p_lbl_started = 1'b0;
  logic [7:0]  p_qtype_hi = '0;
  trl_e        p_trl = TRL_QTYPE_HI;

  dns_question_name_parser dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .msg_first_i      (msg_first),
    .msg_last_i       (msg_last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .value_o          (value),
    .end_of_message_o (end_of_message)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser model: one accepted byte in, at most one predicted result out
  // ---------------------------------------------------------------------------
  task automatic predict_byte(input in_beat_t bt);
    res_t       r;
    bit         have;
    logic [7:0] b;
    b    = bt.data;
    have = 1'b0;
    r    = '{kind: KIND_SEP, value: 16'h0000, eom: 1'b0};

    // msg_first restarts the parser wherever it is
    if (bt.is_first) begin
      p_phase       = PH_HEADER;
      p_hdr_idx     = '0;
      p_q_left      = '0;
      p_lbl_left    = '0;
      p_lbl_started = 1'b0;
      p_qtype_hi    = '0;
      p_trl         = TRL_QTYPE_HI;
    end

    case (p_phase)
      PH_HEADER: begin
        if (p_hdr_idx == HdrFlagsIdx && b[7]) begin
          // response: dropped without a word
          p_phase = PH_DONE;
        end else begin
          if (p_hdr_idx == HdrQdHiIdx) p_q_left = {b, 8'h00};
          else if (p_hdr_idx == HdrQdLoIdx) p_q_left = p_q_left | {8'h00, b};
          if (p_hdr_idx >= HdrLastIdx) begin
            if (p_q_left == 16'h0000) begin
              p_phase = PH_DONE;
            end else begin
              p_phase       = PH_LEN;
              p_lbl_started = 1'b0;
            end
          end else begin
            p_hdr_idx = p_hdr_idx + 4'd1;
          end
        end
      end
      PH_LEN: begin
        if (b == 8'h00) begin
          if (!p_lbl_started) begin
            // empty first label
            r       = '{kind: KIND_MALFORMED, value: 16'h0000, eom: 1'b1};
            have    = 1'b1;
            p_phase = PH_DONE;
          end else begin
            r       = '{kind: KIND_SEP, value: 16'h0000, eom: 1'b0};
            have    = 1'b1;
            p_phase = PH_TRAILER;
            p_trl   = TRL_QTYPE_HI;
          end
        end else begin
          if (p_lbl_started) begin
            r    = '{kind: KIND_SEP, value: 16'h0000, eom: 1'b0};
            have = 1'b1;
          end
          p_lbl_started = 1'b1;
          p_lbl_left    = b;
          p_phase       = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (b == 8'h00) begin
          r       = '{kind: KIND_MALFORMED, value: 16'h0000, eom: 1'b1};
          have    = 1'b1;
          p_phase = PH_DONE;
        end else begin
          if (b >= CharLo && b <= CharHi) r = '{kind: KIND_CHAR, value: {8'h00, b}, eom: 1'b0};
          else r = '{kind: KIND_ESC, value: {8'h00, b}, eom: 1'b0};
          have       = 1'b1;
          p_lbl_left = p_lbl_left - 8'd1;
          if (p_lbl_left == 8'd0) p_phase = PH_LEN;
        end
      end
      PH_TRAILER: begin
        case (p_trl)
          TRL_QTYPE_HI: begin
            p_qtype_hi = b;
            p_trl      = TRL_QTYPE_LO;
          end
          TRL_QTYPE_LO: begin
            p_q_left = p_q_left - 16'd1;
            have     = 1'b1;
            if (p_q_left == 16'h0000) begin
              r       = '{kind: KIND_QDONE, value: {p_qtype_hi, b}, eom: 1'b1};
              p_phase = PH_DONE;
            end else begin
              r     = '{kind: KIND_QDONE, value: {p_qtype_hi, b}, eom: 1'b0};
              p_trl = TRL_QCLASS_HI;
            end
          end
          TRL_QCLASS_HI: p_trl = TRL_QCLASS_LO;
          default: begin
            p_trl         = TRL_QTYPE_HI;
            p_lbl_started = 1'b0;
            p_phase       = PH_LEN;
          end
        endcase
      end
      default: ;  // idle or done: byte ignored
    endcase

    // early end overrides whatever this byte gave
    if (bt.is_last && p_phase != PH_DONE && p_phase != PH_IDLE) begin
      r       = '{kind: KIND_TRUNC, value: 16'h0000, eom: 1'b1};
      have    = 1'b1;
      p_phase = PH_DONE;
    end

    if (have) expected_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // message construction
  // ---------------------------------------------------------------------------
  task automatic add_header(input logic resp, input logic [15:0] qd);
    logic [7:0] hb;
    for (int i = 0; i < 12; i++) begin
      hb = 8'($urandom);
      if (i == HdrFlagsIdx) hb[7] = resp;
      if (i == HdrQdHiIdx) hb = qd[15:8];
      if (i == HdrQdLoIdx) hb = qd[7:0];
      msg_bytes.push_back(hb);
    end
  endtask

  function automatic logic [7:0] label_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(33, 127));
    return 8'($urandom_range(1, 255));
  endfunction

  // one question: name, qtype and qclass, or only an empty name for FLAW_EMPTY_LABEL
  task automatic add_question(input flaw_e flaw);
    int n_labels;
    int len;
    int zpos;
    if (flaw == FLAW_EMPTY_LABEL) begin
      msg_bytes.push_back(8'h00);
      return;
    end
    n_labels = $urandom_range(1, 3);
    for (int l = 0; l < n_labels; l++) begin
      // mostly short labels, now and then a long one up to the full 255
      if ($urandom_range(0, 59) == 0)
        len = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(40, 254);
      else
        len = $urandom_range(1, 8);
      zpos = (flaw == FLAW_ZERO_BYTE && l == 0) ? $urandom_range(0, len - 1) : -1;
      msg_bytes.push_back(8'(len));
      for (int k = 0; k < len; k++) msg_bytes.push_back((k == zpos) ? 8'h00 : label_byte());
    end
    msg_bytes.push_back(8'h00);
    repeat (4) msg_bytes.push_back(8'($urandom));
  endtask

  // move the built message into the send queue
  task automatic send_msg(input bit with_last);
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++)
      pend_beats.push_back('{data: msg_bytes[i], is_first: (i == 0),
                             is_last: (with_last && i == n - 1)});
    stim_items += n;
    msg_bytes.delete();
  endtask

  task automatic build_directed();
    // single beat with both markers: truncated at once
    msg_bytes.push_back(8'hFF);
    send_msg(1'b1);
    // stray byte outside a message
    pend_beats.push_back('{data: 8'h00, is_first: 1'b0, is_last: 1'b1});
    // response flag set: silent, the last marker on the flags byte too
    add_header(1'b1, 16'hFFFF);
    msg_bytes = msg_bytes[0:2];
    send_msg(1'b1);
    // one question with the character boundaries in its label
    add_header(1'b0, 16'd1);
    msg_bytes.push_back(8'd6);
    msg_bytes.push_back(8'h01);
    msg_bytes.push_back(8'h20);
    msg_bytes.push_back(8'h21);
    msg_bytes.push_back(8'h7F);
    msg_bytes.push_back(8'h80);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h00);
    send_msg(1'b1);
  endtask

  task automatic build_random();
    int    pick;
    int    n_q;
    int    cut;
    logic [15:0] qd;
    while (stim_items < RandItems) begin
      pick = $urandom_range(0, 99);
      n_q  = $urandom_range(1, 3);
      if (pick < 60) begin
        // well-formed query, sometimes with bytes after the last question
        add_header(1'b0, 16'(n_q));
        repeat (n_q) add_question(FLAW_NONE);
        repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom));
        send_msg(1'b1);
      end else if (pick < 70) begin
        // cut short, or left open so that the next message restarts it
        add_header(1'b0, 16'(n_q));
        repeat (n_q) add_question(FLAW_NONE);
        cut = $urandom_range(0, msg_bytes.size() - 1);
        msg_bytes = msg_bytes[0:cut];
        send_msg($urandom_range(0, 3) != 0);
      end else if (pick < 75) begin
        add_header(1'b0, 16'(n_q));
        add_question(FLAW_EMPTY_LABEL);
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
        send_msg(1'b1);
      end else if (pick < 80) begin
        add_header(1'b0, 16'(n_q));
        if ($urandom_range(0, 1) == 0) add_question(FLAW_NONE);
        add_question(FLAW_ZERO_BYTE);
        send_msg(1'b1);
      end else if (pick < 84) begin
        add_header(1'b1, 16'(n_q));
        repeat (n_q) add_question(FLAW_NONE);
        send_msg(1'b1);
      end else if (pick < 88) begin
        add_header(1'b0, 16'h0000);
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
        send_msg(1'b1);
      end else if (pick < 92) begin
        // question count larger than the questions present
        qd = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(n_q + 1, 65535));
        add_header(1'b0, qd);
        repeat (n_q) add_question(FLAW_NONE);
        send_msg(1'b1);
      end else begin
        // noise without a first marker
        repeat ($urandom_range(1, 4))
          pend_beats.push_back('{data: 8'($urandom), is_first: 1'b0,
                                 is_last: 1'($urandom)});
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: new beat at the falling edge once the previous one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bit       calm;
    in_beat_t bt;
    calm = (pend_beats.size() < CalmTail);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_beats.size() > 0) begin
        bt = pend_beats.pop_front();
        data_byte <= bt.data;
        msg_first <= bt.is_first;
        msg_last  <= bt.is_last;
        in_valid  <= 1'b1;
        // idle burst after this beat is taken
        if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end

    // result side stalls in bursts of its own
    if (stall_left == 0 && !calm && rst_n && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: beats on both channels seen at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t exp_r;
    bit   out_took;
    in_took  = in_valid && !in_stall;
    out_took = out_valid && !out_stall;
    if (rst_n) begin
      if (in_took) predict_byte('{data: data_byte, is_first: msg_first, is_last: msg_last});
      if (out_took) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("unexpected result beat: kind %0d value %h eom %b",
                     kind, value, end_of_message);
        end else begin
          exp_r = expected_q.pop_front();
          if (kind !== exp_r.kind || value !== exp_r.value || end_of_message !== exp_r.eom) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display("result beat differs: expected kind %0d value %h eom %b,",
                       exp_r.kind, exp_r.value, exp_r.eom,
                       " got kind %0d value %h eom %b",
                       kind, value, end_of_message);
          end
        end
      end
      // watchdog on channel activity
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // all beats sent, then all predictions consumed
    while ((pend_beats.size() != 0 || in_valid) && idle_cycles < IdleLimit) @(posedge clk);
    while (expected_q.size() != 0 && idle_cycles < IdleLimit) @(posedge clk);
    // room for a stray beat still in the pipeline
    repeat (16) @(posedge clk);

    if (idle_cycles >= IdleLimit) mismatch_count++;
    mismatch_count += expected_q.size();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
